FILE: src/lsce_pkg.sv
// Shared widths, register indexes, reset values and pipeline control type.
package lsce_pkg;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int MEAN_W       = 12;
   localparam int VAR_W        = 21;
   localparam int GAIN_W       = 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 21;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Column sum of three pixels, column sum of squares, window sums, 81x variance.
   localparam int COL_SUM_W = 10;
   localparam int COL_SQ_W  = 18;
   localparam int SUM_W     = 12;
   localparam int SQ_W      = 20;
   localparam int D_W       = 23;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MEAN_LIMIT     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_VAR_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_VAR_HIGH_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN           = 3'd5;

   localparam logic [WIDTH_REG_W-1:0]  FRAME_WIDTH_RST    = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
   localparam logic [MEAN_W-1:0]       MEAN_LIMIT_RST     = 12'd0;
   localparam logic [VAR_W-1:0]        VAR_LOW_LIMIT_RST  = 21'd0;
   localparam logic [VAR_W-1:0]        VAR_HIGH_LIMIT_RST = 21'd1300500;
   localparam logic [GAIN_W-1:0]       GAIN_RST           = 8'd5;

   typedef struct packed {
      logic valid;  // stage holds a pixel
      logic emit;   // pixel completes an interior window
      logic last;   // last pixel of the frame
   } ctl_type;

endpackage

FILE: src/local_stats_contrast_enhance.sv
// Top level: 3x3 local-statistics contrast enhancement on a grey pixel stream.
//
// Pixels enter in raster order, one transaction per clock, and the block
// keeps that rate indefinitely: a new pixel is taken every cycle unless the
// result side holds off. Each interior centre (row r-1, column c-1, produced
// when pixel (r, c) with r >= 2 and c >= 2 arrives) leaves through the
// result register; border positions produce no transaction, so the
// consumer fills them. The two previous rows live in one line memory with a
// registered read, one word per column holding both rows; each column is
// read when its pixel arrives and rewritten as that pixel leaves stage 1,
// and because consecutive pixels always hit different columns no
// forwarding is needed. The line memory has no clearing pass and is ready
// right after reset. Geometry and limit registers take effect at once and
// must be written only while no transaction is in flight. A stalled result
// freezes the whole pipeline, line memory read included, so nothing is lost.
module local_stats_contrast_enhance #(
   parameter int MAX_WIDTH  = lsce_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lsce_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel input channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lsce_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsce_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] value
   output logic                              rsp_tlast,
   // Register write port.
   input  logic                              csr_wen,
   input  logic [lsce_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lsce_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lsce_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  frame_width_ff;
   logic [HEIGHT_REG_W-1:0] frame_height_ff;
   logic [MEAN_W-1:0]       mean_limit_ff;
   logic [VAR_W-1:0]        var_low_limit_ff;
   logic [VAR_W-1:0]        var_high_limit_ff;
   logic [GAIN_W-1:0]       gain_ff;

   // Raster position of the next pixel.
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   // Stage 1: pixel waiting for its line memory word.
   ctl_type                 ctl1_ff;
   logic [PIX_W-1:0]        px1_ff;
   logic [COL_W-1:0]        col1_ff;

   logic [WW-1:0]           w_eff;
   logic [HW-1:0]           h_eff;
   logic                    adv;
   logic                    accept;
   logic                    col_end;
   logic                    row_end;
   ctl_type                 ctl_new;
   logic [2*PIX_W-1:0]      line_rd;
   logic                    mem_wr_en;

   ctl_type                 ctl4;
   logic [SUM_W-1:0]        win_sum;
   logic [SQ_W-1:0]         win_sq;
   logic [PIX_W-1:0]        win_centre;
   logic                    out_valid;

   // Clamp geometry to the supported range.
   always_comb begin
      if (frame_width_ff < WIDTH_REG_W'(3)) begin
         w_eff = WW'(3);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(frame_width_ff);
      end
      if (frame_height_ff < HEIGHT_REG_W'(3)) begin
         h_eff = HW'(3);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(frame_height_ff);
      end
   end

   // The whole pipeline moves when the result register is free or being taken.
   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign col_end = (32'(col_ff) + 32'd1) >= 32'(w_eff);
   assign row_end = (32'(row_ff) + 32'd1) >= 32'(h_eff);

   always_comb begin
      ctl_new.valid = accept;
      ctl_new.emit  = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      ctl_new.last  = row_end && col_end;
   end

   // Advance the raster position; wrap at row and frame end.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : ROW_W'(32'(row_ff) + 32'd1);
         end else begin
            col_in = COL_W'(32'(col_ff) + 32'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ctl1_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            ctl1_ff <= ctl_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff  <= req_tdata;
         col1_ff <= col_ff;
      end
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_WIDTH_RST;
         frame_height_ff   <= FRAME_HEIGHT_RST;
         mean_limit_ff     <= MEAN_LIMIT_RST;
         var_low_limit_ff  <= VAR_LOW_LIMIT_RST;
         var_high_limit_ff <= VAR_HIGH_LIMIT_RST;
         gain_ff           <= GAIN_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_wdata[WIDTH_REG_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata[HEIGHT_REG_W-1:0];
            REG_MEAN_LIMIT:     mean_limit_ff     <= csr_wdata[MEAN_W-1:0];
            REG_VAR_LOW_LIMIT:  var_low_limit_ff  <= csr_wdata[VAR_W-1:0];
            REG_VAR_HIGH_LIMIT: var_high_limit_ff <= csr_wdata[VAR_W-1:0];
            REG_GAIN:           gain_ff           <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Line memory word: upper byte is two rows above, lower byte one row above.
   // Rewrite the column as the pixel leaves stage 1: the old row above moves up.
   assign mem_wr_en = adv && ctl1_ff.valid;

   lsce_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (mem_wr_en),
      .wr_addr (col1_ff),
      .wr_data ({line_rd[PIX_W-1:0], px1_ff})
   );

   lsce_window u_window (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl1_ff),
      .up2     (line_rd[2*PIX_W-1:PIX_W]),
      .up      (line_rd[PIX_W-1:0]),
      .px      (px1_ff),
      .ctl_out (ctl4),
      .sum     (win_sum),
      .sq      (win_sq),
      .centre  (win_centre)
   );

   lsce_decide u_decide (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .ctl_in         (ctl4),
      .sum            (win_sum),
      .sq             (win_sq),
      .centre         (win_centre),
      .mean_limit     (mean_limit_ff),
      .var_low_limit  (var_low_limit_ff),
      .var_high_limit (var_high_limit_ff),
      .gain           (gain_ff),
      .out_valid      (out_valid),
      .out_value      (rsp_tdata),
      .out_last       (rsp_tlast)
   );

   assign rsp_tvalid = out_valid;

   // A column is never read and rewritten in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && accept) |-> (col1_ff != col_ff))
      else $error("line memory read and write hit the same column");

   // A stall freezes the line memory read data.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(line_rd))
      else $error("line memory read data changed during a stall");

   // A freshly accepted pixel always sits in stage 1 on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ctl1_ff.valid)
      else $error("accepted pixel missing from stage 1");

endmodule

FILE: src/lsce_line_mem.sv
// Line buffer memory: both previous rows packed per column, registered read.
module lsce_line_mem #(
   parameter int MAX_WIDTH = lsce_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
   output logic [2*lsce_pkg::PIX_W-1:0]       rd_data,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
   input  logic [2*lsce_pkg::PIX_W-1:0]       wr_data
);
   import lsce_pkg::*;

   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/lsce_window.sv
// 3x3 window kept as three column summaries; produces window sum and sum of squares.
module lsce_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  lsce_pkg::ctl_type            ctl_in,
   input  logic [lsce_pkg::PIX_W-1:0]   up2,
   input  logic [lsce_pkg::PIX_W-1:0]   up,
   input  logic [lsce_pkg::PIX_W-1:0]   px,
   output lsce_pkg::ctl_type            ctl_out,
   output logic [lsce_pkg::SUM_W-1:0]   sum,
   output logic [lsce_pkg::SQ_W-1:0]    sq,
   output logic [lsce_pkg::PIX_W-1:0]   centre
);
   import lsce_pkg::*;

   ctl_type              ctl2_ff, ctl3_ff, ctl4_ff;
   logic [COL_SUM_W-1:0] col_sum_ff;
   logic [COL_SQ_W-1:0]  col_sq_ff;
   logic [PIX_W-1:0]     col_mid_ff;
   logic [COL_SUM_W-1:0] win_sum_ff [3];
   logic [COL_SQ_W-1:0]  win_sq_ff  [3];
   logic [PIX_W-1:0]     win_mid_ff [3];
   logic [SUM_W-1:0]     sum_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [PIX_W-1:0]     centre_ff;
   logic [2*PIX_W-1:0]   sq_up2, sq_up, sq_px;

   assign sq_up2 = up2 * up2;
   assign sq_up  = up * up;
   assign sq_px  = px * px;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl2_ff <= ctl_in;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Summarize the incoming column.
         col_sum_ff <= COL_SUM_W'(up2) + COL_SUM_W'(up) + COL_SUM_W'(px);
         col_sq_ff  <= COL_SQ_W'(sq_up2) + COL_SQ_W'(sq_up) + COL_SQ_W'(sq_px);
         col_mid_ff <= up;
         // Shift the window by one column per pixel.
         if (ctl2_ff.valid) begin
            win_sum_ff[0] <= win_sum_ff[1];
            win_sum_ff[1] <= win_sum_ff[2];
            win_sum_ff[2] <= col_sum_ff;
            win_sq_ff[0]  <= win_sq_ff[1];
            win_sq_ff[1]  <= win_sq_ff[2];
            win_sq_ff[2]  <= col_sq_ff;
            win_mid_ff[0] <= win_mid_ff[1];
            win_mid_ff[1] <= win_mid_ff[2];
            win_mid_ff[2] <= col_mid_ff;
         end
         sum_ff    <= SUM_W'(win_sum_ff[0]) + SUM_W'(win_sum_ff[1]) + SUM_W'(win_sum_ff[2]);
         sq_ff     <= SQ_W'(win_sq_ff[0]) + SQ_W'(win_sq_ff[1]) + SQ_W'(win_sq_ff[2]);
         centre_ff <= win_mid_ff[1];
      end
   end

   assign ctl_out = ctl4_ff;
   assign sum     = sum_ff;
   assign sq      = sq_ff;
   assign centre  = centre_ff;

endmodule

FILE: src/lsce_decide.sv
// Variance and mean tests, gain product and the result register.
module lsce_decide (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  lsce_pkg::ctl_type             ctl_in,
   input  logic [lsce_pkg::SUM_W-1:0]    sum,
   input  logic [lsce_pkg::SQ_W-1:0]     sq,
   input  logic [lsce_pkg::PIX_W-1:0]    centre,
   input  logic [lsce_pkg::MEAN_W-1:0]   mean_limit,
   input  logic [lsce_pkg::VAR_W-1:0]    var_low_limit,
   input  logic [lsce_pkg::VAR_W-1:0]    var_high_limit,
   input  logic [lsce_pkg::GAIN_W-1:0]   gain,
   output logic                          out_valid,
   output logic [lsce_pkg::PIX_W-1:0]    out_value,
   output logic                          out_last
);
   import lsce_pkg::*;

   ctl_type              ctl5_ff;
   logic [D_W-1:0]       sq9_ff;
   logic [D_W-1:0]       ss_ff;
   logic                 mean_ok_ff;
   logic [PIX_W-1:0]     prod_ff;
   logic [PIX_W-1:0]     centre_ff;
   logic [2*SUM_W-1:0]   ss;
   logic [PIX_W+GAIN_W-1:0] prod;
   logic [D_W-1:0]       d;
   logic                 hit;
   logic                 out_valid_ff;
   logic [PIX_W-1:0]     out_value_ff;
   logic                 out_last_ff;

   assign ss   = sum * sum;
   assign prod = centre * gain;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq9_ff     <= (D_W'(sq) << 3) + D_W'(sq);
         ss_ff      <= D_W'(ss);
         mean_ok_ff <= (sum <= mean_limit);
         prod_ff    <= prod[PIX_W-1:0];
         centre_ff  <= centre;
      end
   end

   // D is 81 times the local variance and never negative.
   assign d   = sq9_ff - ss_ff;
   assign hit = mean_ok_ff && (d <= D_W'(var_high_limit)) && (d >= D_W'(var_low_limit));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         ctl5_ff      <= ctl_in;
         out_valid_ff <= ctl5_ff.valid && ctl5_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_value_ff <= hit ? prod_ff : centre_ff;
         out_last_ff  <= ctl5_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule
